[rtl/utf8d_pkg.sv]
// Package for the UTF-8 stream decoder.
// Holds the result record type, byte masks and the replacement encoding.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

  localparam logic [7:0]  ASCII_LIMIT = 8'h80;
  localparam logic [7:0]  LEAD2_MASK  = 8'h1f;
  localparam logic [7:0]  CONT_MASK   = 8'h3f;
  localparam logic [7:0]  LEAD3_MASK  = 8'h0f;
  localparam logic [7:0]  LEAD4_MASK  = 8'h07;

  localparam logic [20:0] REPL_CP     = 21'h00fffd;
  localparam logic [7:0]  REPL_BYTE0  = 8'hef;
  localparam logic [7:0]  REPL_BYTE1  = 8'hbf;
  localparam logic [7:0]  REPL_BYTE2  = 8'hbd;

  localparam logic [2:0]  LEN_1       = 3'd1;
  localparam logic [2:0]  LEN_2       = 3'd2;
  localparam logic [2:0]  LEN_3       = 3'd3;
  localparam logic [2:0]  LEN_4       = 3'd4;

  typedef struct packed {
    logic [20:0] code_point;
    logic [7:0]  enc_byte0;
    logic [7:0]  enc_byte1;
    logic [7:0]  enc_byte2;
    logic [7:0]  enc_byte3;
    logic [2:0]  enc_length;
    logic        invalid;
  } result_t;

endpackage

`default_nettype wire

[rtl/utf8d_decode.sv]
// Per-byte decoder: sequence state registers and the decode logic.
// Produces at most one result record for each accepted byte.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_take,
  input  wire logic [7:0]        byte_in,
  output utf8d_pkg::result_t     res,
  output logic                   res_valid
);

  logic [1:0]  rem_r, rem_nxt;
  logic [2:0]  total_r, total_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic [7:0]  held_r [3];
  logic [7:0]  held_nxt [3];

  logic [1:0]  rem_dec;
  logic [2:0]  pos;
  logic [20:0] acc_shift;

  always_comb begin
    rem_dec   = rem_r - 2'd1;
    pos       = total_r - {1'b0, rem_dec} - 3'd1;
    acc_shift = {acc_r[14:0], byte_in[5:0] & utf8d_pkg::CONT_MASK[5:0]};

    rem_nxt     = rem_r;
    total_nxt   = total_r;
    acc_nxt     = acc_r;
    held_nxt[0] = held_r[0];
    held_nxt[1] = held_r[1];
    held_nxt[2] = held_r[2];
    res_valid   = 1'b0;
    res         = '0;

    if (rem_r == 2'd0) begin
      if (byte_in < utf8d_pkg::ASCII_LIMIT) begin
        res_valid      = 1'b1;
        res.code_point = {13'd0, byte_in};
        res.enc_byte0  = byte_in;
        res.enc_length = utf8d_pkg::LEN_1;
      end else if (byte_in inside {[8'hc0:8'hf7]}) begin
        if (byte_in inside {[8'hc0:8'hdf]}) begin
          acc_nxt   = {13'd0, byte_in & utf8d_pkg::LEAD2_MASK};
          total_nxt = utf8d_pkg::LEN_2;
          rem_nxt   = 2'd1;
        end else if (byte_in inside {[8'he0:8'hef]}) begin
          acc_nxt   = {13'd0, byte_in & utf8d_pkg::LEAD3_MASK};
          total_nxt = utf8d_pkg::LEN_3;
          rem_nxt   = 2'd2;
        end else begin
          acc_nxt   = {13'd0, byte_in & utf8d_pkg::LEAD4_MASK};
          total_nxt = utf8d_pkg::LEN_4;
          rem_nxt   = 2'd3;
        end
        held_nxt[0] = byte_in;
        held_nxt[1] = 8'd0;
        held_nxt[2] = 8'd0;
      end else begin
        res_valid      = 1'b1;
        res.code_point = utf8d_pkg::REPL_CP;
        res.enc_byte0  = utf8d_pkg::REPL_BYTE0;
        res.enc_byte1  = utf8d_pkg::REPL_BYTE1;
        res.enc_byte2  = utf8d_pkg::REPL_BYTE2;
        res.enc_length = utf8d_pkg::LEN_3;
        res.invalid    = 1'b1;
      end
    end else begin
      acc_nxt = acc_shift;
      rem_nxt = rem_dec;
      if (rem_dec != 2'd0) begin
        if (pos == 3'd1) begin
          held_nxt[1] = byte_in;
        end else if (pos == 3'd2) begin
          held_nxt[2] = byte_in;
        end
      end else begin
        res_valid      = 1'b1;
        res.code_point = acc_shift;
        res.enc_byte0  = held_r[0];
        if (total_r == utf8d_pkg::LEN_2) begin
          res.enc_byte1  = byte_in;
          res.enc_length = utf8d_pkg::LEN_2;
        end else if (total_r == utf8d_pkg::LEN_3) begin
          res.enc_byte1  = held_r[1];
          res.enc_byte2  = byte_in;
          res.enc_length = utf8d_pkg::LEN_3;
        end else begin
          res.enc_byte1  = held_r[1];
          res.enc_byte2  = held_r[2];
          res.enc_byte3  = byte_in;
          res.enc_length = utf8d_pkg::LEN_4;
        end
        total_nxt   = 3'd0;
        acc_nxt     = 21'd0;
        held_nxt[0] = 8'd0;
        held_nxt[1] = 8'd0;
        held_nxt[2] = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r     <= 2'd0;
      total_r   <= 3'd0;
      acc_r     <= 21'd0;
      held_r[0] <= 8'd0;
      held_r[1] <= 8'd0;
      held_r[2] <= 8'd0;
    end else if (byte_take) begin
      rem_r     <= rem_nxt;
      total_r   <= total_nxt;
      acc_r     <= acc_nxt;
      held_r[0] <= held_nxt[0];
      held_r[1] <= held_nxt[1];
      held_r[2] <= held_nxt[2];
    end
  end

endmodule

`default_nettype wire

[rtl/utf8d_out_buf.sv]
// Two-entry result buffer between the decoder and the output channel.
// The second entry lets the decoder keep taking bytes while a result waits.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_out_buf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire utf8d_pkg::result_t push_data,
  output logic                   has_room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output utf8d_pkg::result_t     out_data
);

  utf8d_pkg::result_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  always_comb begin
    has_room   = (cnt_r != 2'd2);
    out_valid  = (cnt_r != 2'd0);
    out_data   = entry_r[rd_ptr_r];
    pop        = out_valid && out_ready;
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/utf8_stream_decoder.sv]
// UTF-8 stream decoder, top level.
// Accepts one byte per beat on the in_ channel and returns decoded characters
// on the out_ channel. Each result beat carries the code point, the raw
// encoding bytes (unused ones are zero), the length and an invalid flag.
// A byte below 0x80 yields a result for that beat. A lead byte starts a
// sequence and the result appears with its last continuation byte; bytes in
// between yield nothing. A stray continuation byte or a lead byte with five or
// more leading ones yields U+FFFD (EF BF BD) with the invalid flag set.
// A result is written into the result buffer with the beat that completes it
// and is presented on out_valid from there. Throughput: one byte per cycle
// while in_ready is high; decode from the sequence state is combinational.
// A two-entry result buffer keeps in_ready high while one result waits; when
// the receiver stalls for longer, in_ready falls once both entries are full.
// Reset (rst_n low, synchronous) drops any partial sequence and empties the
// buffer; no reset pass is needed and the block accepts bytes right after.
// Depends on utf8d_pkg, utf8d_decode and utf8d_out_buf.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [20:0]      out_code_point,
  output logic [7:0]       out_enc_byte0,
  output logic [7:0]       out_enc_byte1,
  output logic [7:0]       out_enc_byte2,
  output logic [7:0]       out_enc_byte3,
  output logic [2:0]       out_enc_length,
  output logic             out_invalid
);

  utf8d_pkg::result_t dec_res;
  utf8d_pkg::result_t buf_res;
  logic               dec_valid;
  logic               buf_room;
  logic               take;

  assign in_ready = buf_room;
  assign take     = in_valid && buf_room;

  utf8d_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (take),
    .byte_in   (in_byte),
    .res       (dec_res),
    .res_valid (dec_valid)
  );

  utf8d_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take && dec_valid),
    .push_data (dec_res),
    .has_room  (buf_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (buf_res)
  );

  assign out_code_point = buf_res.code_point;
  assign out_enc_byte0  = buf_res.enc_byte0;
  assign out_enc_byte1  = buf_res.enc_byte1;
  assign out_enc_byte2  = buf_res.enc_byte2;
  assign out_enc_byte3  = buf_res.enc_byte3;
  assign out_enc_length = buf_res.enc_length;
  assign out_invalid    = buf_res.invalid;

endmodule

`default_nettype wire

[rtl/utf8d_checker.sv]
// Port-level checker for the UTF-8 stream decoder and its bind statement.
// Checks result consistency and output stall behavior.
// Depends on utf8_stream_decoder and utf8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [20:0] out_code_point,
  input wire logic [7:0]  out_enc_byte0,
  input wire logic [7:0]  out_enc_byte1,
  input wire logic [7:0]  out_enc_byte2,
  input wire logic [7:0]  out_enc_byte3,
  input wire logic [2:0]  out_enc_length,
  input wire logic        out_invalid
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_point) &&
      $stable(out_enc_length) && $stable(out_enc_byte0))
    else $error("result beat changed while stalled");

  a_invalid_repl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_code_point == utf8d_pkg::REPL_CP &&
      out_enc_length == utf8d_pkg::LEN_3 && out_enc_byte0 == utf8d_pkg::REPL_BYTE0 &&
      out_enc_byte3 == 8'd0)
    else $error("invalid result without the replacement encoding");

  a_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_enc_length == utf8d_pkg::LEN_1 |->
      out_code_point == {13'd0, out_enc_byte0} && out_enc_byte0[7] == 1'b0 &&
      out_enc_byte1 == 8'd0 && out_enc_byte2 == 8'd0 && out_enc_byte3 == 8'd0)
    else $error("single-byte result inconsistent");

  a_short_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_enc_length == utf8d_pkg::LEN_2 |->
      out_enc_byte2 == 8'd0 && out_enc_byte3 == 8'd0 && !out_invalid &&
      out_code_point == {10'd0, out_enc_byte0[4:0], out_enc_byte1[5:0]})
    else $error("two-byte result inconsistent");

endmodule

bind utf8_stream_decoder utf8d_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_code_point (out_code_point),
  .out_enc_byte0  (out_enc_byte0),
  .out_enc_byte1  (out_enc_byte1),
  .out_enc_byte2  (out_enc_byte2),
  .out_enc_byte3  (out_enc_byte3),
  .out_enc_length (out_enc_length),
  .out_invalid    (out_invalid)
);

`default_nettype wire
